FILE: rtl/core/pbcs_pkg.sv
// package: shared types and constants of the bezier curve sampler
`timescale 1ns / 1ps
package pbcs_pkg;

  localparam int unsigned CAP_W   = 13;
  localparam int unsigned PPS_W   = 6;
  localparam int unsigned SEG_W   = 7;
  localparam int unsigned NUM_W   = 6;
  localparam int unsigned STORE_W = 9;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned CFG_IDX_W = 2;

  // t is unsigned q1.16 and reaches 1.0
  localparam int unsigned T_W        = 17;
  localparam int unsigned EXTRA_FRAC = 8;
  localparam int unsigned T_FRAC     = 16;
  localparam int unsigned CAP_BIAS   = 10;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND     = 2'd0,
    CMD_DROP_FIRST = 2'd1,
    CMD_DROP_LAST  = 2'd2,
    CMD_EMIT       = 2'd3
  } cmd_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_STATUS = 2'd0,
    KIND_SAMPLE = 2'd1,
    KIND_ABSENT = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAPACITY = 2'd0,
    CFG_MIN_PPS  = 2'd1,
    CFG_MAX_PPS  = 2'd2
  } cfg_idx_e;

  localparam logic [CAP_W-1:0] CAP_RESET = 13'd256;
  localparam logic [PPS_W-1:0] MIN_RESET = 6'd10;
  localparam logic [PPS_W-1:0] MAX_RESET = 6'd50;

endpackage

FILE: rtl/core/piecewise_bezier_curve_sampler_core.sv
// Piecewise cubic bezier curve sampler: point ring, tangents and de Casteljau evaluation.
//
// A request is taken at a rising edge with start high and busy low. cmd selects
// append (point_x_i/point_y_i), remove first, remove last or emit the samples
// of segment segment_index_i. Each result is held for one cycle under
// result_valid_o; the receiver cannot stall, last_o marks the final result of
// a request. Config registers are written through cfg_we_i, cfg_idx_i and
// cfg_data_i; the user must do so only while the block is idle, which the
// block itself does not enforce.
// The shared restoring divider gives one quotient bit a cycle. An append or
// remove runs one divide for the per-segment count before its status result;
// the divide is skipped when fewer than four points are left. An emit of an
// absent or cut-off segment takes the same path. An emit with samples runs
// one divide for the sample count, one for the t step, six point reads from the
// ring memory and four tangent sixths by reciprocal multiplication, then
// gives its samples, each after six lerps per coordinate through one
// multiplier per axis.
// busy falls in the cycle that carries the final result.
// Reset empties the ring and loads the register defaults; the point memories
// are not cleared, an empty slot is never read.
`timescale 1ns / 1ps
module piecewise_bezier_curve_sampler_core #(
  parameter int unsigned MAX_POINTS  = 256,
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [pbcs_pkg::CMD_W-1:0]            cmd_i,
  input  logic signed [COORD_WIDTH-1:0]         point_x_i,
  input  logic signed [COORD_WIDTH-1:0]         point_y_i,
  input  logic [pbcs_pkg::SEG_W-1:0]            segment_index_i,
  input  logic                                  cfg_we_i,
  input  logic [pbcs_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [pbcs_pkg::CAP_W-1:0]            cfg_data_i,
  output logic                                  result_valid_o,
  output logic [pbcs_pkg::KIND_W-1:0]           kind_o,
  output logic signed [COORD_WIDTH-1:0]         sample_x_o,
  output logic signed [COORD_WIDTH-1:0]         sample_y_o,
  output logic [pbcs_pkg::NUM_W-1:0]            sample_number_o,
  output logic [pbcs_pkg::STORE_W-1:0]          stored_points_o,
  output logic [pbcs_pkg::SEG_W-1:0]            segment_total_o,
  output logic [pbcs_pkg::PPS_W-1:0]            per_segment_o,
  output logic                                  last_o
);

  localparam int unsigned CW   = COORD_WIDTH;
  localparam int unsigned HW   = $clog2(MAX_POINTS);
  localparam int unsigned CNTW = $clog2(MAX_POINTS + 1);
  localparam int unsigned LW   = ((CNTW > 9) ? CNTW : 9) + 1;
  localparam int unsigned SCW  = ((CNTW > 7) ? CNTW : 7) + 1;
  localparam int unsigned VW   = CW + 10;
  localparam int unsigned DVW  = CW + 10;
  localparam int unsigned DSW  = (CNTW > 7) ? CNTW : 7;
  localparam int unsigned DCW  = $clog2(DVW + 1);
  localparam int unsigned PW   = VW + 1 + pbcs_pkg::T_W + 1;
  localparam int unsigned MW   = pbcs_pkg::CAP_W + 1;
  localparam int unsigned RK   = CW + 12;

  localparam logic [CNTW-1:0] MAX_CNT  = CNTW'(MAX_POINTS);
  localparam logic [HW:0]     MAX_SLOT = (HW + 1)'(MAX_POINTS);
  localparam logic signed [VW-1:0] SAT_HI = VW'((64'd1 << (CW - 1)) - 64'd1);
  localparam logic signed [VW-1:0] SAT_LO = -SAT_HI - VW'(1);
  localparam logic signed [PW-1:0] HALF_T = PW'(64'd1 << (pbcs_pkg::T_FRAC - 1));
  localparam logic signed [VW-1:0] HALF_F = VW'(64'd1 << (pbcs_pkg::EXTRA_FRAC - 1));
  // ceil(2^RK / 6), exact for every tangent numerator
  localparam logic [DVW-1:0] RECIP6 = DVW'(((64'd1 << RK) + 64'd5) / 64'd6);

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_DIV, S_CLAMP, S_RESP, S_QR, S_READ, S_SIXTH, S_SIXTH_W,
    S_CTRL, S_EVAL
  } state_e;

  state_e                 state_q, ret_q;

  // configuration
  logic [pbcs_pkg::CAP_W-1:0] cap_q;
  logic [pbcs_pkg::PPS_W-1:0] min_q, max_q;

  // ring bookkeeping; count = 3*tri + mod3
  logic [HW-1:0]          head_q;
  logic [CNTW-1:0]        count_q, tri_q;
  logic [1:0]             mod3_q;

  logic [pbcs_pkg::CMD_W-1:0] cmd_q;
  logic [pbcs_pkg::SEG_W-1:0] seg_q;
  logic [pbcs_pkg::PPS_W-1:0] pps_q;

  // divider
  logic [DVW-1:0]         dv_quo_q;
  logic [DSW:0]           dv_rem_q;
  logic [DSW-1:0]         dv_den_q;
  logic [DCW-1:0]         dv_cnt_q;
  logic [DSW:0]           dv_shift, dv_rem_d;
  logic                   dv_ge;

  // point memories
  logic signed [CW-1:0]   x_mem [MAX_POINTS];
  logic signed [CW-1:0]   y_mem [MAX_POINTS];
  logic signed [CW-1:0]   rdx_q, rdy_q;
  logic [HW-1:0]          rd_addr, wr_addr;
  logic                   wr_en;

  logic [2:0]             rd_cnt_q;
  logic signed [CW-1:0]   pt_q [2][6];
  logic [1:0]             sx_cnt_q;
  logic                   sx_neg_q;
  logic signed [VW-1:0]   sx_q [4];
  logic [2*DVW-1:0]       sx_prod;
  logic [VW-1:0]          sx_quo;

  logic signed [VW-1:0]   c_q [2][4];
  logic signed [VW-1:0]   d_q [2][3];
  logic signed [VW-1:0]   e_q [2][2];
  logic [2:0]             step_q;
  logic [pbcs_pkg::NUM_W-1:0] i_q;
  logic [pbcs_pkg::T_W-1:0]   t_q, tq_step_q;
  logic [pbcs_pkg::PPS_W-1:0] tr_q, tr_step_q;

  logic                   res_valid_q, last_q;
  logic [pbcs_pkg::KIND_W-1:0] kind_q;
  logic signed [CW-1:0]   outx_q, outy_q;
  logic [pbcs_pkg::NUM_W-1:0] num_q;

  logic                   accept;
  logic [CNTW-1:0]        segs_w;
  logic [HW:0]            slot_sum;
  logic [LW-1:0]          p_idx, l_idx;
  logic [HW:0]            rd_sum;
  logic signed [CW:0]     delta;
  logic [CW:0]            mag;
  logic [DVW-1:0]         sx_num;
  logic [DVW-1:0]         base1, base2, base3;
  logic [MW-1:0]          reach;
  logic                   seg_bad, last_seg, last_i;
  logic [pbcs_pkg::PPS_W:0] tr_sum;
  logic signed [VW-1:0]   la [2], lb [2], lr [2], fin [2];
  logic signed [CW-1:0]   sat [2];

  assign accept = start && (state_q == S_IDLE);
  assign busy   = (state_q != S_IDLE);

  assign segs_w = (count_q >= CNTW'(4)) ? ((mod3_q == 2'd0) ? tri_q - CNTW'(1) : tri_q)
                                         : '0;

  // append slot: oldest slot when the ring is full
  assign slot_sum = {1'b0, head_q} + (HW + 1)'(count_q);
  always_comb begin
    if (count_q == MAX_CNT) begin
      wr_addr = head_q;
    end else if (slot_sum >= MAX_SLOT) begin
      wr_addr = HW'(slot_sum - MAX_SLOT);
    end else begin
      wr_addr = HW'(slot_sum);
    end
  end
  assign wr_en = accept && (pbcs_pkg::cmd_e'(cmd_i) == pbcs_pkg::CMD_APPEND);

  // read list: p-1, p, p+1, q-1, q, q+1 with the end points folded inwards
  assign p_idx = LW'(seg_q) * LW'(3);
  always_comb begin
    case (rd_cnt_q)
      3'd0:    l_idx = (p_idx == '0) ? p_idx : p_idx - LW'(1);
      3'd1:    l_idx = p_idx;
      3'd2:    l_idx = p_idx + LW'(1);
      3'd3:    l_idx = p_idx + LW'(2);
      3'd4:    l_idx = p_idx + LW'(3);
      default: l_idx = ((p_idx + LW'(4)) >= LW'(count_q)) ? p_idx + LW'(3)
                                                         : p_idx + LW'(4);
    endcase
    rd_sum = {1'b0, head_q} + {1'b0, l_idx[HW-1:0]};
    rd_addr = (rd_sum >= MAX_SLOT) ? HW'(rd_sum - MAX_SLOT) : HW'(rd_sum);
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      x_mem[wr_addr] <= point_x_i;
      y_mem[wr_addr] <= point_y_i;
    end
    rdx_q <= x_mem[rd_addr];
    rdy_q <= y_mem[rd_addr];
  end

  // restoring divider step
  assign dv_shift = {dv_rem_q[DSW-1:0], dv_quo_q[DVW-1]};
  assign dv_ge    = dv_shift >= {1'b0, dv_den_q};
  assign dv_rem_d = dv_ge ? dv_shift - {1'b0, dv_den_q} : dv_shift;

  // tangent delta for the divide by six
  always_comb begin
    if (sx_cnt_q[1]) begin
      delta = $signed({pt_q[sx_cnt_q[0]][5][CW-1], pt_q[sx_cnt_q[0]][5]})
            - $signed({pt_q[sx_cnt_q[0]][3][CW-1], pt_q[sx_cnt_q[0]][3]});
    end else begin
      delta = $signed({pt_q[sx_cnt_q[0]][2][CW-1], pt_q[sx_cnt_q[0]][2]})
            - $signed({pt_q[sx_cnt_q[0]][0][CW-1], pt_q[sx_cnt_q[0]][0]});
    end
    mag    = delta[CW] ? (CW + 1)'(-delta) : (CW + 1)'(delta);
    sx_num = (DVW'(mag) << pbcs_pkg::EXTRA_FRAC) + DVW'(3);
  end

  // registered numerator divided by six through the reciprocal
  assign sx_prod = (2 * DVW)'(dv_quo_q) * (2 * DVW)'(RECIP6);
  assign sx_quo  = VW'(sx_prod >> RK);

  // clamp of the per-segment count
  always_comb begin
    base1 = (dv_quo_q < DVW'(min_q)) ? DVW'(min_q) : dv_quo_q;
    base2 = (base1 > DVW'(max_q)) ? DVW'(max_q) : base1;
    base3 = (base2 == '0) ? DVW'(1) : base2;
  end

  assign reach    = MW'(SCW'(seg_q) + SCW'(1)) * MW'(pps_q);
  assign seg_bad  = (SCW'(seg_q) >= SCW'(segs_w)) || (reach >= MW'(cap_q));
  assign last_seg = (SCW'(seg_q) + SCW'(1)) == SCW'(segs_w);
  assign last_i   = last_seg ? (i_q == pps_q) : (i_q == pps_q - pbcs_pkg::PPS_W'(1));
  assign tr_sum   = {1'b0, tr_q} + {1'b0, tr_step_q};

  // one lerp per axis and cycle
  always_comb begin
    for (int c = 0; c < 2; c++) begin
      logic signed [VW:0]   diff;
      logic signed [PW-1:0] de, te, prod;
      case (step_q)
        3'd0:    begin la[c] = c_q[c][0]; lb[c] = c_q[c][1]; end
        3'd1:    begin la[c] = c_q[c][1]; lb[c] = c_q[c][2]; end
        3'd2:    begin la[c] = c_q[c][2]; lb[c] = c_q[c][3]; end
        3'd3:    begin la[c] = d_q[c][0]; lb[c] = d_q[c][1]; end
        3'd4:    begin la[c] = d_q[c][1]; lb[c] = d_q[c][2]; end
        default: begin la[c] = e_q[c][0]; lb[c] = e_q[c][1]; end
      endcase
      diff  = $signed({lb[c][VW-1], lb[c]}) - $signed({la[c][VW-1], la[c]});
      de    = PW'(diff);
      te    = PW'($signed({1'b0, t_q}));
      prod  = de * te;
      lr[c] = la[c] + VW'((prod + HALF_T) >>> pbcs_pkg::T_FRAC);
      fin[c] = (lr[c] + HALF_F) >>> pbcs_pkg::EXTRA_FRAC;
      if (fin[c] > SAT_HI) begin
        sat[c] = CW'(SAT_HI);
      end else if (fin[c] < SAT_LO) begin
        sat[c] = CW'(SAT_LO);
      end else begin
        sat[c] = CW'(fin[c]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      cap_q       <= pbcs_pkg::CAP_RESET;
      min_q       <= pbcs_pkg::MIN_RESET;
      max_q       <= pbcs_pkg::MAX_RESET;
      head_q      <= '0;
      count_q     <= '0;
      tri_q       <= '0;
      mod3_q      <= '0;
      pps_q       <= '0;
      dv_cnt_q    <= '0;
      rd_cnt_q    <= '0;
      sx_cnt_q    <= '0;
      step_q      <= '0;
      i_q         <= '0;
      res_valid_q <= 1'b0;
      last_q      <= 1'b0;
      kind_q      <= pbcs_pkg::KIND_STATUS;
    end else begin
      res_valid_q <= 1'b0;
      if (cfg_we_i) begin
        case (pbcs_pkg::cfg_idx_e'(cfg_idx_i))
          pbcs_pkg::CFG_CAPACITY: cap_q <= cfg_data_i;
          pbcs_pkg::CFG_MIN_PPS:  min_q <= cfg_data_i[pbcs_pkg::PPS_W-1:0];
          pbcs_pkg::CFG_MAX_PPS:  max_q <= cfg_data_i[pbcs_pkg::PPS_W-1:0];
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            cmd_q   <= cmd_i;
            seg_q   <= segment_index_i;
            state_q <= S_PREP;
            case (pbcs_pkg::cmd_e'(cmd_i))
              pbcs_pkg::CMD_APPEND: begin
                if (count_q == MAX_CNT) begin
                  head_q <= (head_q == HW'(MAX_POINTS - 1)) ? '0 : head_q + HW'(1);
                end else begin
                  count_q <= count_q + CNTW'(1);
                  if (mod3_q == 2'd2) begin
                    mod3_q <= 2'd0;
                    tri_q  <= tri_q + CNTW'(1);
                  end else begin
                    mod3_q <= mod3_q + 2'd1;
                  end
                end
              end
              pbcs_pkg::CMD_DROP_FIRST, pbcs_pkg::CMD_DROP_LAST: begin
                if (count_q != '0) begin
                  if (pbcs_pkg::cmd_e'(cmd_i) == pbcs_pkg::CMD_DROP_FIRST) begin
                    head_q <= (head_q == HW'(MAX_POINTS - 1)) ? '0 : head_q + HW'(1);
                  end
                  count_q <= count_q - CNTW'(1);
                  if (mod3_q == 2'd0) begin
                    mod3_q <= 2'd2;
                    tri_q  <= tri_q - CNTW'(1);
                  end else begin
                    mod3_q <= mod3_q - 2'd1;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        S_PREP: begin
          if (segs_w == '0) begin
            pps_q   <= '0;
            state_q <= S_RESP;
          end else begin
            dv_quo_q <= (cap_q >= pbcs_pkg::CAP_W'(pbcs_pkg::CAP_BIAS))
                      ? DVW'(cap_q - pbcs_pkg::CAP_W'(pbcs_pkg::CAP_BIAS)) : '0;
            dv_den_q <= DSW'(segs_w);
            dv_rem_q <= '0;
            dv_cnt_q <= '0;
            ret_q    <= S_CLAMP;
            state_q  <= S_DIV;
          end
        end
        S_DIV: begin
          dv_rem_q <= dv_rem_d;
          dv_quo_q <= {dv_quo_q[DVW-2:0], dv_ge};
          dv_cnt_q <= dv_cnt_q + DCW'(1);
          if (dv_cnt_q == DCW'(DVW - 1)) begin
            state_q <= ret_q;
          end
        end
        S_CLAMP: begin
          pps_q   <= pbcs_pkg::PPS_W'(base3);
          state_q <= S_RESP;
        end
        S_RESP: begin
          if (pbcs_pkg::cmd_e'(cmd_q) != pbcs_pkg::CMD_EMIT || seg_bad) begin
            res_valid_q <= 1'b1;
            last_q      <= 1'b1;
            kind_q      <= (pbcs_pkg::cmd_e'(cmd_q) == pbcs_pkg::CMD_EMIT)
                         ? pbcs_pkg::KIND_ABSENT : pbcs_pkg::KIND_STATUS;
            outx_q      <= '0;
            outy_q      <= '0;
            num_q       <= '0;
            state_q     <= S_IDLE;
          end else begin
            // step of t: 1.0 / per_segment as quotient and remainder
            dv_quo_q <= DVW'(64'd1 << pbcs_pkg::T_FRAC);
            dv_den_q <= DSW'(pps_q);
            dv_rem_q <= '0;
            dv_cnt_q <= '0;
            ret_q    <= S_QR;
            state_q  <= S_DIV;
          end
        end
        S_QR: begin
          tq_step_q <= pbcs_pkg::T_W'(dv_quo_q);
          tr_step_q <= pbcs_pkg::PPS_W'(dv_rem_q);
          rd_cnt_q  <= '0;
          state_q   <= S_READ;
        end
        S_READ: begin
          // memory data is registered and arrives in the cycle after its address
          if (rd_cnt_q != 3'd0) begin
            pt_q[0][rd_cnt_q - 3'd1] <= rdx_q;
            pt_q[1][rd_cnt_q - 3'd1] <= rdy_q;
          end
          rd_cnt_q <= rd_cnt_q + 3'd1;
          if (rd_cnt_q == 3'd6) begin
            sx_cnt_q <= '0;
            state_q  <= S_SIXTH;
          end
        end
        S_SIXTH: begin
          sx_neg_q <= delta[CW];
          dv_quo_q <= sx_num;
          state_q  <= S_SIXTH_W;
        end
        S_SIXTH_W: begin
          sx_q[sx_cnt_q] <= sx_neg_q ? -sx_quo : sx_quo;
          sx_cnt_q       <= sx_cnt_q + 2'd1;
          state_q        <= (sx_cnt_q == 2'd3) ? S_CTRL : S_SIXTH;
        end
        S_CTRL: begin
          for (int c = 0; c < 2; c++) begin
            c_q[c][0] <= VW'(pt_q[c][1]) <<< pbcs_pkg::EXTRA_FRAC;
            c_q[c][1] <= (VW'(pt_q[c][1]) <<< pbcs_pkg::EXTRA_FRAC) + sx_q[c];
            c_q[c][2] <= (VW'(pt_q[c][4]) <<< pbcs_pkg::EXTRA_FRAC) - sx_q[2 + c];
            c_q[c][3] <= VW'(pt_q[c][4]) <<< pbcs_pkg::EXTRA_FRAC;
          end
          i_q     <= '0;
          t_q     <= '0;
          tr_q    <= pps_q >> 1;
          step_q  <= '0;
          state_q <= S_EVAL;
        end
        S_EVAL: begin
          for (int c = 0; c < 2; c++) begin
            case (step_q)
              3'd0:    d_q[c][0] <= lr[c];
              3'd1:    d_q[c][1] <= lr[c];
              3'd2:    d_q[c][2] <= lr[c];
              3'd3:    e_q[c][0] <= lr[c];
              3'd4:    e_q[c][1] <= lr[c];
              default: ;
            endcase
          end
          if (step_q == 3'd5) begin
            res_valid_q <= 1'b1;
            kind_q      <= pbcs_pkg::KIND_SAMPLE;
            outx_q      <= sat[0];
            outy_q      <= sat[1];
            num_q       <= i_q;
            last_q      <= last_i;
            step_q      <= '0;
            i_q         <= i_q + pbcs_pkg::NUM_W'(1);
            if (tr_sum >= {1'b0, pps_q}) begin
              tr_q <= pbcs_pkg::PPS_W'(tr_sum - {1'b0, pps_q});
              t_q  <= t_q + tq_step_q + pbcs_pkg::T_W'(1);
            end else begin
              tr_q <= pbcs_pkg::PPS_W'(tr_sum);
              t_q  <= t_q + tq_step_q;
            end
            if (last_i) begin
              state_q <= S_IDLE;
            end
          end else begin
            step_q <= step_q + 3'd1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign result_valid_o  = res_valid_q;
  assign kind_o          = kind_q;
  assign sample_x_o      = outx_q;
  assign sample_y_o      = outy_q;
  assign sample_number_o = num_q;
  assign stored_points_o = pbcs_pkg::STORE_W'(count_q);
  assign segment_total_o = pbcs_pkg::SEG_W'(segs_w);
  assign per_segment_o   = pps_q;
  assign last_o          = last_q;

endmodule

FILE: rtl/core/pbcs_checker.sv
// checker: port-level properties of the bezier curve sampler, bound to the top level
`timescale 1ns / 1ps
module pbcs_checker #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            start,
  input logic                            busy,
  input logic                            result_valid_o,
  input logic [pbcs_pkg::KIND_W-1:0]     kind_o,
  input logic signed [COORD_WIDTH-1:0]   sample_x_o,
  input logic signed [COORD_WIDTH-1:0]   sample_y_o,
  input logic                            last_o
);

  // a request always moves the block out of idle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("request taken but block not busy");

  // only samples come in runs, everything else closes its request
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && kind_o != pbcs_pkg::KIND_SAMPLE |-> last_o)
    else $error("status result without last");

  a_more_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |-> busy) else $error("idle in the middle of a run");

  a_kind_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> kind_o == pbcs_pkg::KIND_STATUS || kind_o == pbcs_pkg::KIND_SAMPLE ||
    kind_o == pbcs_pkg::KIND_ABSENT) else $error("undefined result kind");

  a_zero_coords: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && kind_o != pbcs_pkg::KIND_SAMPLE |-> sample_x_o == '0 && sample_y_o == '0)
    else $error("coordinates on a non-sample result");

endmodule

bind piecewise_bezier_curve_sampler_core pbcs_checker #(.COORD_WIDTH(COORD_WIDTH))
  u_pbcs_checker (
  .clk_i, .rst_ni, .start, .busy, .result_valid_o, .kind_o, .sample_x_o, .sample_y_o, .last_o
);
